FILE: hdl/token_bucket_pacer_assert.svh
// Assertion macros used by the pacer RTL.
`ifndef TOKEN_BUCKET_PACER_ASSERT_SVH
`define TOKEN_BUCKET_PACER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, idle during reset.
`define TBP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pacer check failed");

// Next-cycle implication, sampled on the rising clock, idle during reset.
`define TBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pacer check failed");

`endif

FILE: hdl/tbp_pkg.sv
package tbp_pkg;

    localparam int TIME_WIDTH      = 64;
    localparam int RATE_WIDTH      = 32;
    localparam int BURST_WIDTH     = 32;
    localparam int BYTES_WIDTH     = 16;
    localparam int WAIT_WIDTH      = 40;
    localparam int CFG_INDEX_WIDTH = 4;
    localparam int CFG_DATA_WIDTH  = 64;
    localparam int PROD_WIDTH      = TIME_WIDTH + RATE_WIDTH;

    localparam logic [RATE_WIDTH-1:0]  RATE_RESET        = 32'd209715;
    localparam logic [BURST_WIDTH-1:0] BURST_RESET       = 32'd1250000;
    localparam logic [31:0]            INIT_TOKENS_RESET = 32'd12500000;
    localparam logic [TIME_WIDTH-1:0]  START_TIME_RESET  = 64'd0;

    localparam logic [WAIT_WIDTH-1:0]  WAIT_MAX = '1;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_RATE_Q24       = 4'd0,
        REG_BURST_LIMIT    = 4'd1,
        REG_INITIAL_TOKENS = 4'd2,
        REG_START_TIME     = 4'd3
    } tbp_reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC,
        ST_REFILL,
        ST_CAP,
        ST_DECIDE,
        ST_DIV,
        ST_DONE
    } tbp_state_t;

    typedef struct packed {
        logic [RATE_WIDTH-1:0]  rate;
        logic [BURST_WIDTH-1:0] burst;
        logic                   tokens_we;
        logic                   refill_we;
    } tbp_cfg_t;

    typedef struct packed {
        logic in_load;
        logic mul_lo;
        logic mul_hi;
        logic acc_add;
        logic refill;
        logic cap;
        logic decide;
        logic div_step;
        logic out_load;
    } tbp_cmd_t;

    typedef struct packed {
        logic grant;
        logic div_last;
        logic out_free;
    } tbp_status_t;

endpackage

FILE: hdl/token_bucket_pacer.sv
// A packet runs through the multiply (low and high halves), accumulate, refill,
// cap and decide states; a refused one then runs the bit-serial wait divider,
// and the result waits for the output register. A new packet is taken only after
// the last result has been loaded into the output register.
// Reset (async, active low) loads the register defaults, the token count and the
// last refill time, and empties the output register.
`include "token_bucket_pacer_assert.svh"

module token_bucket_pacer #(
    parameter int RATE_FRACTION_BITS = 24,
    parameter int TOKEN_WIDTH        = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tbp_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [tbp_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [tbp_pkg::TIME_WIDTH-1:0]       now_time,
    input  logic [tbp_pkg::BYTES_WIDTH-1:0]      packet_bytes,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 granted,
    output logic [tbp_pkg::WAIT_WIDTH-1:0]       wait_time
);
    import tbp_pkg::*;

    tbp_cfg_t    cfg;
    tbp_cmd_t    cmd;
    tbp_status_t status;

    tbp_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tbp_dp #(
        .RATE_FRACTION_BITS (RATE_FRACTION_BITS),
        .TOKEN_WIDTH        (TOKEN_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .now_time     (now_time),
        .packet_bytes (packet_bytes),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .granted      (granted),
        .wait_time    (wait_time)
    );

    // A granted packet never reports a wait.
    `TBP_ASSERT_SAME(a_grant_no_wait, clk, rst_n, out_valid && granted, wait_time == '0)
    // Packets are taken one at a time: a transfer closes the input for the next cycle.
    `TBP_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)
    // With no refill a refused packet waits the longest time that can be reported.
    `TBP_ASSERT_SAME(a_zero_rate_wait, clk, rst_n, out_valid && !granted && cfg.rate == '0,
                     wait_time == WAIT_MAX)

endmodule

FILE: hdl/tbp_regs.sv
module tbp_regs (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tbp_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [tbp_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    output tbp_pkg::tbp_cfg_t                     cfg
);
    import tbp_pkg::*;

    logic [RATE_WIDTH-1:0]  rate_reg;
    logic [BURST_WIDTH-1:0] burst_reg;
    logic                   tokens_we;
    logic                   refill_we;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        tokens_we = 1'b0;
        refill_we = 1'b0;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_INITIAL_TOKENS: tokens_we = 1'b1;
                REG_START_TIME:     refill_we = 1'b1;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= RATE_RESET;
            burst_reg <= BURST_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_RATE_Q24:    rate_reg  <= cfg_data[RATE_WIDTH-1:0];
                REG_BURST_LIMIT: burst_reg <= cfg_data[BURST_WIDTH-1:0];
                default:         ;
            endcase
        end
    end

    assign cfg.rate      = rate_reg;
    assign cfg.burst     = burst_reg;
    assign cfg.tokens_we = tokens_we;
    assign cfg.refill_we = refill_we;

endmodule

FILE: hdl/tbp_ctrl.sv
module tbp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tbp_pkg::tbp_status_t  status,
    output tbp_pkg::tbp_cmd_t     cmd
);
    import tbp_pkg::*;

    tbp_state_t state_reg;
    tbp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = ST_MUL_LO;
                end
            end
            ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc_add = 1'b1;
                state_next  = ST_REFILL;
            end
            ST_REFILL:
            begin
                cmd.refill = 1'b1;
                state_next = ST_CAP;
            end
            ST_CAP:
            begin
                cmd.cap    = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = status.grant ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold the result until the output register can take it.
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/tbp_dp.sv
module tbp_dp #(
    parameter int RATE_FRACTION_BITS = 24,
    parameter int TOKEN_WIDTH        = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tbp_pkg::tbp_cfg_t                    cfg,
    input  logic [tbp_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    input  tbp_pkg::tbp_cmd_t                    cmd,
    output tbp_pkg::tbp_status_t                 status,
    input  logic [tbp_pkg::TIME_WIDTH-1:0]       now_time,
    input  logic [tbp_pkg::BYTES_WIDTH-1:0]      packet_bytes,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 granted,
    output logic [tbp_pkg::WAIT_WIDTH-1:0]       wait_time
);
    import tbp_pkg::*;

    localparam int HALF_WIDTH = TIME_WIDTH / 2;
    localparam int EXT_WIDTH  = TOKEN_WIDTH + 32;
    localparam int SAT_SHIFT  = RATE_FRACTION_BITS + TOKEN_WIDTH;
    localparam int DIV_WIDTH  = BYTES_WIDTH + RATE_FRACTION_BITS;
    localparam int CNT_WIDTH  = $clog2(DIV_WIDTH);
    localparam int QEXT_WIDTH = DIV_WIDTH + WAIT_WIDTH;

    localparam logic [TOKEN_WIDTH-1:0] TOKEN_MAX = '1;
    localparam logic [CNT_WIDTH-1:0]   LAST_STEP = CNT_WIDTH'(DIV_WIDTH - 1);

    // Clamp a 32-bit register value to the token range.
    function automatic logic [TOKEN_WIDTH-1:0] sat_tokens(input logic [31:0] v);
        logic [EXT_WIDTH-1:0] v_ext;
        v_ext = EXT_WIDTH'(v);
        if (v_ext > EXT_WIDTH'(TOKEN_MAX))
            return TOKEN_MAX;
        return TOKEN_WIDTH'(v_ext);
    endfunction

    localparam logic [TOKEN_WIDTH-1:0] TOKEN_RESET = sat_tokens(INIT_TOKENS_RESET);

    logic [TIME_WIDTH-1:0]  last_refill_reg;
    logic [TOKEN_WIDTH-1:0] token_reg;
    logic [TIME_WIDTH-1:0]  elapsed_reg;
    logic [BYTES_WIDTH-1:0] bytes_reg;
    logic [TIME_WIDTH-1:0]  prod_reg;
    logic [PROD_WIDTH-1:0]  acc_reg;
    logic [TOKEN_WIDTH-1:0] add_reg;
    logic [TOKEN_WIDTH-1:0] tok_reg;
    logic                   grant_reg;
    logic [DIV_WIDTH-1:0]   dq_reg;
    logic [RATE_WIDTH-1:0]  rem_reg;
    logic [CNT_WIDTH-1:0]   step_reg;
    logic                   out_valid_reg;
    logic                   granted_reg;
    logic [WAIT_WIDTH-1:0]  wait_reg;

    logic [HALF_WIDTH-1:0]  mul_a;
    logic [TOKEN_WIDTH-1:0] refill_q;
    logic [TOKEN_WIDTH:0]   tok_sum;
    logic [TOKEN_WIDTH-1:0] tok_sat;
    logic [TOKEN_WIDTH-1:0] cap;
    logic                   grant;
    logic [BYTES_WIDTH-1:0] deficit;
    logic [RATE_WIDTH:0]    rem_sh;
    logic [RATE_WIDTH:0]    rate_ext;
    logic                   rem_ge;
    logic [QEXT_WIDTH-1:0]  q_ext;
    logic [WAIT_WIDTH-1:0]  wait_val;

    assign mul_a    = cmd.mul_lo ? elapsed_reg[HALF_WIDTH-1:0]
                                 : elapsed_reg[TIME_WIDTH-1:HALF_WIDTH];
    assign refill_q = (|(acc_reg >> SAT_SHIFT)) ? TOKEN_MAX
                                                : TOKEN_WIDTH'(acc_reg >> RATE_FRACTION_BITS);
    assign tok_sum  = (TOKEN_WIDTH + 1)'(token_reg) + (TOKEN_WIDTH + 1)'(add_reg);
    assign tok_sat  = tok_sum[TOKEN_WIDTH] ? TOKEN_MAX : tok_sum[TOKEN_WIDTH-1:0];
    assign cap      = sat_tokens(cfg.burst);
    assign grant    = tok_reg >= TOKEN_WIDTH'(bytes_reg);
    assign deficit  = bytes_reg - tok_reg[BYTES_WIDTH-1:0];

    // One quotient bit per cycle: restoring division of deficit * 2^F by the rate.
    assign rate_ext = {1'b0, cfg.rate};
    assign rem_sh   = {rem_reg, dq_reg[DIV_WIDTH-1]};
    assign rem_ge   = rem_sh >= rate_ext;

    assign q_ext    = QEXT_WIDTH'(dq_reg);
    assign wait_val = (cfg.rate == '0 || (|(q_ext >> WAIT_WIDTH))) ? WAIT_MAX
                                                                  : q_ext[WAIT_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg       <= TOKEN_RESET;
            last_refill_reg <= START_TIME_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.tokens_we)
            begin
                token_reg <= sat_tokens(cfg_data[31:0]);
            end
            else if (cmd.decide)
            begin
                token_reg <= grant ? tok_reg - TOKEN_WIDTH'(bytes_reg) : tok_reg;
            end

            if (cfg.refill_we)
            begin
                last_refill_reg <= cfg_data[TIME_WIDTH-1:0];
            end
            else if (cmd.in_load)
            begin
                last_refill_reg <= now_time;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            elapsed_reg <= now_time - last_refill_reg;
            bytes_reg   <= packet_bytes;
        end
        if (cmd.mul_lo || cmd.mul_hi)
        begin
            prod_reg <= TIME_WIDTH'(mul_a) * TIME_WIDTH'(cfg.rate);
        end
        if (cmd.mul_hi)
        begin
            acc_reg <= PROD_WIDTH'(prod_reg);
        end
        if (cmd.acc_add)
        begin
            acc_reg[PROD_WIDTH-1:HALF_WIDTH] <= acc_reg[PROD_WIDTH-1:HALF_WIDTH] + prod_reg;
        end
        if (cmd.refill)
        begin
            add_reg <= refill_q;
        end
        if (cmd.cap)
        begin
            tok_reg <= (tok_sat > cap) ? cap : tok_sat;
        end
        if (cmd.decide)
        begin
            grant_reg <= grant;
            dq_reg    <= {deficit, {RATE_FRACTION_BITS{1'b0}}};
            rem_reg   <= '0;
            step_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            dq_reg   <= {dq_reg[DIV_WIDTH-2:0], rem_ge};
            rem_reg  <= rem_ge ? RATE_WIDTH'(rem_sh - rate_ext) : rem_sh[RATE_WIDTH-1:0];
            step_reg <= step_reg + 1'b1;
        end
        if (cmd.out_load)
        begin
            granted_reg <= grant_reg;
            wait_reg    <= grant_reg ? '0 : wait_val;
        end
    end

    assign status.grant    = grant;
    assign status.div_last = step_reg == LAST_STEP;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign granted   = granted_reg;
    assign wait_time = wait_reg;

endmodule

FILE: tb/token_bucket_pacer_tb.sv
`timescale 1ns / 100ps

module token_bucket_pacer_tb;
    import tbp_pkg::*;

    localparam int FRAC_BITS = 24;
    localparam logic [31:0] TOKEN_FULL = '1;
    localparam int RANDOM_ITEMS = 550;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [TIME_WIDTH-1:0]  now;
        logic [BYTES_WIDTH-1:0] bytes;
    } packet_t;

    typedef struct packed {
        logic                  granted;
        logic [WAIT_WIDTH-1:0] wait_ns;
    } verdict_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [TIME_WIDTH-1:0]      now_time = '0;
    logic [BYTES_WIDTH-1:0]     packet_bytes = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic                       granted;
    logic [WAIT_WIDTH-1:0]      wait_time;

    packet_t  packet_q[$];
    verdict_t verdict_q[$];
    packet_t  offered;
    verdict_t due;

    // Our own copy of the bucket and its settings.
    logic [RATE_WIDTH-1:0]  rate_q24 = RATE_RESET;
    logic [BURST_WIDTH-1:0] burst_limit = BURST_RESET;
    logic [31:0]            token_count = INIT_TOKENS_RESET;
    logic [TIME_WIDTH-1:0]  last_refill = START_TIME_RESET;

    int   accepted_cnt = 0;
    int   mismatches = 0;
    int   tx_gap = 0;
    int   rx_gap = 0;
    logic hold_active = 1'b0;
    logic no_idle = 1'b0;

    token_bucket_pacer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .now_time     (now_time),
        .packet_bytes (packet_bytes),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .granted      (granted),
        .wait_time    (wait_time)
    );

    always #1 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(99, 0);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        if (r < 98)
            return $urandom_range(20, 4);
        return $urandom_range(150, 40);
    endfunction

    function automatic void load_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                          input logic [CFG_DATA_WIDTH-1:0] data);
        case (idx)
            REG_RATE_Q24:       rate_q24 = data[RATE_WIDTH-1:0];
            REG_BURST_LIMIT:    burst_limit = data[BURST_WIDTH-1:0];
            REG_INITIAL_TOKENS: token_count = data[31:0];
            REG_START_TIME:     last_refill = data[TIME_WIDTH-1:0];
            default: ;
        endcase
    endfunction

    function automatic verdict_t pace_packet(input packet_t pkt);
        logic [TIME_WIDTH-1:0] elapsed;
        logic [PROD_WIDTH-1:0] product;
        logic [PROD_WIDTH-1:0] refill;
        logic [32:0]           sum;
        logic [31:0]           level;
        logic [31:0]           deficit;
        logic [63:0]           quotient;
        verdict_t              v;
        elapsed = pkt.now - last_refill;
        product = {{RATE_WIDTH{1'b0}}, elapsed} * {{TIME_WIDTH{1'b0}}, rate_q24};
        refill = product >> FRAC_BITS;
        // Both the refill and the refilled count saturate before the burst cap.
        sum = {1'b0, token_count}
            + ((refill > TOKEN_FULL) ? {1'b0, TOKEN_FULL} : {1'b0, refill[31:0]});
        level = sum[32] ? TOKEN_FULL : sum[31:0];
        if (level > burst_limit)
            level = burst_limit;
        last_refill = pkt.now;
        if (level >= {16'd0, pkt.bytes})
        begin
            token_count = level - {16'd0, pkt.bytes};
            v.granted = 1'b1;
            v.wait_ns = '0;
        end
        else
        begin
            token_count = level;
            deficit = {16'd0, pkt.bytes} - level;
            v.granted = 1'b0;
            if (rate_q24 == '0)
                v.wait_ns = WAIT_MAX;
            else
            begin
                quotient = ({32'd0, deficit} << FRAC_BITS) / {32'd0, rate_q24};
                v.wait_ns = (quotient > {24'd0, WAIT_MAX}) ? WAIT_MAX
                                                           : quotient[WAIT_WIDTH-1:0];
            end
        end
        return v;
    endfunction

    // Packet driver: the prediction is made at the transfer itself.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                verdict_q.push_back(pace_packet(offered));
                accepted_cnt <= accepted_cnt + 1;
                tx_gap = no_idle ? 0 : gap_len();
            end
            if (!in_valid || in_ready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap = tx_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (packet_q.size() > 0)
                begin
                    offered = packet_q.pop_front();
                    now_time <= offered.now;
                    packet_bytes <= offered.bytes;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: granted=%0d wait_time=%0d",
                                 granted, wait_time);
                end
                else
                begin
                    due = verdict_q.pop_front();
                    if (granted !== due.granted || wait_time !== due.wait_ns)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch: exp granted=%0d wait=%0d got granted=%0d wait=%0d",
                                     due.granted, due.wait_ns, granted, wait_time);
                    end
                end
                rx_gap = no_idle ? 0 : gap_len();
            end
            if (hold_active)
                out_ready <= 1'b0;
            else if (rx_gap > 0)
            begin
                rx_gap = rx_gap - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Long back-pressure while packets are still waiting, so the input stalls.
    initial
    begin
        do
            @(posedge clk);
        while (packet_q.size() <= 40 || accepted_cnt <= 100);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        load_register(idx, data);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (packet_q.size() != 0 || in_valid || verdict_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic program_bucket(input logic [RATE_WIDTH-1:0] rate,
                                  input logic [BURST_WIDTH-1:0] burst,
                                  input logic [31:0] tokens,
                                  input logic [TIME_WIDTH-1:0] start);
        settle();
        write_reg(REG_RATE_Q24, CFG_DATA_WIDTH'(rate));
        write_reg(REG_BURST_LIMIT, CFG_DATA_WIDTH'(burst));
        write_reg(REG_INITIAL_TOKENS, CFG_DATA_WIDTH'(tokens));
        write_reg(REG_START_TIME, start);
        @(negedge clk);
    endtask

    task automatic queue_packet(input logic [TIME_WIDTH-1:0] now,
                                input logic [BYTES_WIDTH-1:0] bytes);
        packet_t pkt;
        pkt.now = now;
        pkt.bytes = bytes;
        packet_q.push_back(pkt);
    endtask

    initial
    begin : stimulus
        int                     idx;
        int                     sent;
        int                     count;
        logic [RATE_WIDTH-1:0]  rate;
        logic [BURST_WIDTH-1:0] burst;
        logic [31:0]            tokens;
        logic [TIME_WIDTH-1:0]  start;
        logic [TIME_WIDTH-1:0]  stamp;
        logic [15:0]            bytes_max;
        logic [63:0]            step_max;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset defaults: the initial count sits above the burst limit until the
        // first refill caps it. Time also steps backwards and jumps to its maximum.
        queue_packet(64'd0, 16'd0);
        queue_packet(64'd0, '1);
        queue_packet(64'd2000, 16'd1500);
        queue_packet(64'd1000, 16'd1);
        queue_packet('1, '1);

        // With no refill at all, a refused packet waits the saturated maximum.
        program_bucket('0, 32'd5000, 32'd100, 64'd100);
        queue_packet(64'd200, 16'd50);
        queue_packet(64'd300, 16'd60);
        queue_packet(64'd400, 16'd50);
        queue_packet(64'd500, 16'd0);

        // Slowest rate and an empty bucket: the longest finite wait, across a wrap.
        program_bucket(32'd1, '0, '0, 64'hFFFF_FFFF_FFFF_FFF0);
        queue_packet(64'hFFFF_FFFF_FFFF_FFF0, '1);
        queue_packet(64'd0, 16'd1);
        queue_packet(64'd10, 16'd0);

        // Full-scale rate and limits saturate both the refill and the sum.
        program_bucket('1, '1, '1, 64'd0);
        queue_packet(64'h1_0000_0000, '1);
        queue_packet(64'h1_0000_0000, '1);
        queue_packet('1, 16'd1);

        // Writes to unused indexes leave the bucket alone; then a live restart.
        settle();
        for (idx = int'(REG_START_TIME) + 1; idx < (1 << CFG_INDEX_WIDTH); idx++)
            write_reg(idx[CFG_INDEX_WIDTH-1:0], {$urandom, $urandom});
        write_reg(REG_RATE_Q24, CFG_DATA_WIDTH'(RATE_RESET));
        write_reg(REG_INITIAL_TOKENS, 64'd10);
        write_reg(REG_START_TIME, 64'd5000);
        @(negedge clk);
        queue_packet(64'd5000, 16'd20);
        queue_packet(64'd5000, 16'd10);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(9, 0))
                0:       rate = 32'd1;
                1:       rate = '1;
                2:       rate = $urandom;
                default: rate = $urandom_range(1 << 26, 1 << 12);
            endcase
            if (rate == '0)
                rate = 32'd1;
            case ($urandom_range(7, 0))
                0:       burst = '0;
                1:       burst = '1;
                2:       burst = $urandom;
                default: burst = $urandom_range(200000, 100);
            endcase
            case ($urandom_range(5, 0))
                0:       tokens = $urandom;
                1:       tokens = burst;
                default: tokens = $urandom_range(burst, 0);
            endcase
            start = {$urandom, $urandom};
            case ($urandom_range(3, 0))
                0:       bytes_max = 16'd64;
                1:       bytes_max = 16'd1500;
                2:       bytes_max = 16'd9000;
                default: bytes_max = '1;
            endcase
            // Space the timestamps so that the refill roughly matches the demand,
            // which keeps grants and refusals mixed.
            step_max = ({48'd0, bytes_max} << FRAC_BITS) / {32'd0, rate};
            if (step_max > 64'h7FFF_FFFF)
                step_max = 64'h7FFF_FFFF;
            if (step_max == 64'd0)
                step_max = 64'd1;

            program_bucket(rate, burst, tokens, start);
            no_idle <= ($urandom_range(3, 0) == 0);
            stamp = start;
            count = $urandom_range(90, 50);
            repeat (count)
            begin
                if ($urandom_range(24, 0) == 0)
                begin
                    stamp = {$urandom, $urandom};
                    queue_packet(stamp, 16'($urandom));
                end
                else
                begin
                    stamp = stamp + TIME_WIDTH'($urandom_range(step_max[31:0], 0));
                    queue_packet(stamp, 16'($urandom_range(bytes_max, 0)));
                end
            end
            sent = sent + count;
        end

        settle();
        repeat (50) @(posedge clk);
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("** token_bucket_pacer: PASSED **");
        else
            $display("** token_bucket_pacer: FAILED **");
        $finish;
    end

    initial
    begin
        #(2_000_000);
        $display("** token_bucket_pacer: FAILED **");
        $finish;
    end

endmodule
